### rtl/core/igfr_pkg.sv
package igfr_pkg;

   // Receiver modes.
   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_RECV  = 2'd1,
      MODE_READY = 2'd2
   } mode_type;

   // Item kinds carried on the action field.
   typedef enum logic [1:0] {
      ACT_BYTE = 2'd0,
      ACT_TICK = 2'd1,
      ACT_READ = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   // Register indexes on the configuration port.
   localparam logic CSR_SILENCE_TIMEOUT = 1'b0;
   localparam logic CSR_MAX_LENGTH      = 1'b1;

   localparam int CSR_DATA_W = 16;

   localparam logic [15:0] TIMEOUT_RESET = 16'd50;
   localparam logic [7:0]  MAX_LEN_RESET = 8'd128;
   localparam logic [15:0] TIMER_MAX     = 16'hFFFF;

   // Side information that travels with a read from the control logic.
   typedef struct packed {
      logic       last;
      logic [7:0] length;
   } rd_info_type;

endpackage

### rtl/core/igfr_store.sv
module igfr_store
   import igfr_pkg::*;
#(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] store_mem [DEPTH];
   logic [7:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/igfr_ctrl.sv
module igfr_ctrl
   import igfr_pkg::*;
#(
   parameter int DEPTH = 128,
   parameter int AW    = 7,
   parameter int CW    = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [1:0]            action,
   input  logic [7:0]            rx_byte,
   input  logic [15:0]           tick_period,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  wr_en,
   output logic [AW-1:0]         wr_addr,
   output logic [7:0]            wr_data,
   output logic                  rd_en,
   output logic [AW-1:0]         rd_addr,
   output rd_info_type           rd_info
);

   localparam int LW = (CW > 8) ? CW : 8;

   mode_type      mode_ff, mode_in;
   logic [CW-1:0] count_ff, count_in;
   logic [15:0]   timer_ff, timer_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [15:0]   timeout_ff;
   logic [7:0]    max_len_ff;

   action_type    act;
   logic [16:0]   timer_sum;
   logic [LW-1:0] count_ext;
   logic [LW-1:0] max_len_ext;
   logic          room;
   logic [CW:0]   idx_plus;
   logic          last;

   assign act         = action_type'(action);
   assign timer_sum   = {1'b0, timer_ff} + {1'b0, tick_period};
   assign count_ext   = LW'(count_ff);
   assign max_len_ext = LW'(max_len_ff);
   assign room        = (count_ext < max_len_ext) && (count_ext < LW'(DEPTH));
   assign idx_plus    = (CW + 1)'(rd_idx_ff) + (CW + 1)'(1);
   assign last        = idx_plus >= (CW + 1)'(count_ff);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SILENCE_TIMEOUT: timeout_ff <= csr_wdata[15:0];
            CSR_MAX_LENGTH:      max_len_ff <= csr_wdata[7:0];
            default:             timeout_ff <= timeout_ff;
         endcase
      end
   end

   // Next state of the mode, counters and silence timer.
   always_comb begin
      mode_in   = mode_ff;
      count_in  = count_ff;
      timer_in  = timer_ff;
      rd_idx_in = rd_idx_ff;
      if (accept) begin
         unique case (act)
            ACT_BYTE: begin
               if (mode_ff == MODE_IDLE) begin
                  mode_in  = MODE_RECV;
                  timer_in = '0;
                  count_in = CW'(1);
               end else if (mode_ff == MODE_RECV) begin
                  timer_in = '0;
                  if (room) begin
                     count_in = count_ff + CW'(1);
                  end
               end
            end
            ACT_TICK: begin
               if (timer_ff < timeout_ff) begin
                  timer_in = timer_sum[16] ? TIMER_MAX : timer_sum[15:0];
               end else if (mode_ff == MODE_RECV) begin
                  mode_in   = MODE_READY;
                  rd_idx_in = '0;
               end
            end
            ACT_READ: begin
               if (mode_ff == MODE_READY) begin
                  if (last) begin
                     mode_in   = MODE_IDLE;
                     rd_idx_in = '0;
                  end else begin
                     rd_idx_in = AW'(idx_plus);
                  end
               end
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   // Store accesses and read side information.
   always_comb begin
      wr_en          = 1'b0;
      wr_addr        = '0;
      wr_data        = rx_byte;
      rd_en          = 1'b0;
      rd_addr        = rd_idx_ff;
      rd_info.last   = last;
      rd_info.length = count_ext[7:0];
      if (accept) begin
         unique case (act)
            ACT_BYTE: begin
               if (mode_ff == MODE_IDLE) begin
                  wr_en = 1'b1;
               end else if (mode_ff == MODE_RECV && room) begin
                  wr_en   = 1'b1;
                  wr_addr = AW'(count_ff);
               end
            end
            ACT_READ: begin
               rd_en = (mode_ff == MODE_READY);
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   // Control state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         count_ff  <= '0;
         timer_ff  <= '0;
         rd_idx_ff <= '0;
      end else begin
         mode_ff   <= mode_in;
         count_ff  <= count_in;
         timer_ff  <= timer_in;
         rd_idx_ff <= rd_idx_in;
      end
   end

endmodule

### rtl/core/idle_gap_frame_receiver_core.sv
// A read beat is registered in the store, then in the output register, before it is sent out.
// One item per cycle while req_stall is low; the frame store has one write and one read port.
// Byte and tick items produce no beat and update state in the cycle they are accepted.
// Reset clears mode, counters, timer and the result pipeline and loads timeout 50 and
// maximum length 128; the frame store is not cleared and needs no clearing pass.
module idle_gap_frame_receiver_core
   import igfr_pkg::*;
#(
   parameter int BUFFER_DEPTH = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_action,
   input  logic [7:0]            req_rx_byte,
   input  logic [15:0]           req_tick_period,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_frame_byte,
   output logic                  rsp_last_byte,
   output logic [7:0]            rsp_frame_length,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int CW = $clog2(BUFFER_DEPTH + 1);

   logic          accept;
   logic          advance;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;
   rd_info_type   rd_info;

   logic          s1_valid_ff;
   rd_info_type   s1_info_ff;
   logic          out_valid_ff;
   logic [7:0]    out_byte_ff;
   logic          out_last_ff;
   logic [7:0]    out_len_ff;

   // The output register moves when empty or when its beat is taken.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   igfr_ctrl #(
      .DEPTH (BUFFER_DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .action      (req_action),
      .rx_byte     (req_rx_byte),
      .tick_period (req_tick_period),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_info     (rd_info)
   );

   igfr_store #(
      .DEPTH (BUFFER_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Read-in-flight stage, waiting on the store's registered data.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (rd_en) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_info_ff <= rd_info;
      end
   end

   // Output register for the result beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         out_byte_ff <= rd_data;
         out_last_ff <= s1_info_ff.last;
         out_len_ff  <= s1_info_ff.length;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_frame_byte   = out_byte_ff;
   assign rsp_last_byte    = out_last_ff;
   assign rsp_frame_length = out_len_ff;

endmodule

### dv/idle_gap_frame_receiver_core_test.sv
module idle_gap_frame_receiver_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import igfr_pkg::*;

   localparam int DEPTH = 128;

   typedef struct {
      action_type  act;
      logic [7:0]  rx_byte;
      logic [15:0] tick_period;
   } rx_item_type;

   typedef struct {
      logic [7:0] frame_byte;
      logic       last_byte;
      logic [7:0] frame_length;
   } frame_beat_type;

   // Block ports; every input starts at a known value.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_action = 2'd0;
   logic [7:0]            req_rx_byte = 8'd0;
   logic [15:0]           req_tick_period = 16'd0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [7:0]            rsp_frame_byte;
   logic                  rsp_last_byte;
   logic [7:0]            rsp_frame_length;
   logic                  csr_we = 1'b0;
   logic                  csr_index = CSR_SILENCE_TIMEOUT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Items waiting to be sent and beats the receiver is expected to return.
   rx_item_type    pending_items[$];
   frame_beat_type beats_due[$];
   rx_item_type    offered_item;

   // Shadow copy of the receiver state and its registers.
   mode_type    rx_mode = MODE_IDLE;
   int unsigned rx_count = 0;
   int unsigned rx_timer = 0;
   int unsigned rd_pos = 0;
   logic [7:0]  frame_mem [0:DEPTH-1];
   int unsigned cfg_timeout = TIMEOUT_RESET;
   int unsigned cfg_max_len = MAX_LEN_RESET;

   int unsigned items_taken = 0;
   int unsigned beats_seen = 0;
   int unsigned frames_read = 0;
   int unsigned reg_writes = 0;
   int unsigned mismatches = 0;
   int unsigned long_holds_asked = 0;
   int unsigned long_holds_done = 0;

   idle_gap_frame_receiver_core #(
      .BUFFER_DEPTH(DEPTH)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_rx_byte     (req_rx_byte),
      .req_tick_period (req_tick_period),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_frame_byte  (rsp_frame_byte),
      .rsp_last_byte   (rsp_last_byte),
      .rsp_frame_length(rsp_frame_length),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the shadow receiver by one accepted item and queue any beat it yields.
   function automatic void step_receiver(input rx_item_type item);
      int unsigned lim;
      int unsigned sum;
      frame_beat_type beat;
      lim = (cfg_max_len > DEPTH) ? DEPTH : cfg_max_len;
      case (item.act)
         ACT_BYTE: begin
            if (rx_mode == MODE_IDLE) begin
               rx_mode = MODE_RECV;
               rx_timer = 0;
               frame_mem[0] = item.rx_byte;
               rx_count = 1;
            end else if (rx_mode == MODE_RECV) begin
               rx_timer = 0;
               if (rx_count < lim) begin
                  frame_mem[rx_count] = item.rx_byte;
                  rx_count++;
               end
            end
         end
         ACT_TICK: begin
            if (rx_timer < cfg_timeout) begin
               sum = rx_timer + item.tick_period;
               rx_timer = (sum > TIMER_MAX) ? TIMER_MAX : sum;
            end else if (rx_mode == MODE_RECV) begin
               rx_mode = MODE_READY;
               rd_pos = 0;
            end
         end
         ACT_READ: begin
            if (rx_mode == MODE_READY) begin
               beat.frame_byte   = frame_mem[rd_pos];
               beat.last_byte    = (rd_pos + 1 >= rx_count);
               beat.frame_length = 8'(rx_count);
               beats_due.push_back(beat);
               if (beat.last_byte) begin
                  rx_mode = MODE_IDLE;
                  rd_pos = 0;
               end else begin
                  rd_pos++;
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("MISMATCH at %0t: %s", $realtime, msg);
      end
   endfunction

   // Idle length for either side: mostly none, some short, a few long.
   function automatic int unsigned pick_idle(input bit calm);
      int unsigned r;
      if (calm) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 65) begin
         return 0;
      end else if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic void add_item(input action_type act, input int unsigned rx,
                                    input int unsigned period);
      rx_item_type item;
      item.act         = act;
      item.rx_byte     = 8'(rx);
      item.tick_period = 16'(period);
      pending_items.push_back(item);
   endfunction

   // One frame: bytes, silence, maybe a stray byte, then reads for every stored byte, maybe one more.
   function automatic int unsigned add_frame(input int unsigned len);
      int unsigned lim;
      int unsigned kept;
      int unsigned n;
      n = 0;
      for (int i = 0; i < len; i++) begin
         add_item(ACT_BYTE, $urandom, $urandom);
         n++;
         if (cfg_timeout > 3 && $urandom_range(0, 11) == 0) begin
            add_item(ACT_TICK, $urandom, $urandom_range(0, cfg_timeout / 4));
            n++;
         end
      end
      // The first tick reaches the timeout, the second closes the frame; a zero timeout closes it at once.
      if (cfg_timeout == 0) begin
         add_item(ACT_TICK, $urandom, $urandom);
      end else begin
         add_item(ACT_TICK, $urandom, $urandom_range(cfg_timeout, 65535));
      end
      add_item(ACT_TICK, $urandom, $urandom);
      n += 2;
      if ($urandom_range(0, 7) == 0) begin
         add_item(ACT_BYTE, $urandom, $urandom);
      end
      lim = (cfg_max_len > DEPTH) ? DEPTH : cfg_max_len;
      kept = (len > lim) ? lim : len;
      if (kept == 0) begin
         kept = 1;
      end
      kept += $urandom_range(0, 1);
      for (int i = 0; i < kept; i++) begin
         add_item(ACT_READ, $urandom, $urandom);
      end
      return n + kept;
   endfunction

   // Random items of any kind, including the unused action.
   function automatic int unsigned add_noise();
      int unsigned n;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         add_item(action_type'($urandom_range(0, 3)), $urandom, $urandom);
      end
      return n;
   endfunction

   task automatic write_reg(input logic idx, input logic [15:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_SILENCE_TIMEOUT) begin
         cfg_timeout = value;
      end else begin
         cfg_max_len = value[7:0];
      end
      reg_writes++;
   endtask

   // The sender holds back until every expected beat is home, then the block settles.
   task automatic drain_block();
      int unsigned waited;
      waited = 0;
      while (pending_items.size() > 0 || req_valid) @(negedge clock);
      while (beats_due.size() > 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      if (beats_due.size() > 0) begin
         report_mismatch($sformatf("%0d expected beats never arrived", beats_due.size()));
         beats_due.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   // Sender: offers queued items with random gaps and feeds accepted items to the shadow.
   int unsigned req_gap = 0;
   int unsigned req_calm_left = 0;
   bit          req_calm = 1'b0;

   always @(posedge clock) begin : req_driver
      rx_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            step_receiver(offered_item);
            items_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               item = pending_items.pop_front();
               offered_item    = item;
               req_action      <= item.act;
               req_rx_byte     <= item.rx_byte;
               req_tick_period <= item.tick_period;
               req_valid       <= 1'b1;
               req_gap = pick_idle(req_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (req_calm_left == 0) begin
            req_calm = ($urandom_range(0, 3) == 0);
            req_calm_left = $urandom_range(50, 300);
         end else begin
            req_calm_left--;
         end
      end
   end

   // Receiver: checks each accepted beat and stalls at random or on request.
   int unsigned rsp_hold = 0;
   int unsigned rsp_calm_left = 0;
   bit          rsp_calm = 1'b0;

   always @(posedge clock) begin : rsp_monitor
      frame_beat_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            beats_seen++;
            if (beats_due.size() == 0) begin
               report_mismatch($sformatf("unexpected beat: byte %02h last %0b length %0d",
                                         rsp_frame_byte, rsp_last_byte, rsp_frame_length));
            end else begin
               want = beats_due.pop_front();
               if (rsp_frame_byte !== want.frame_byte || rsp_last_byte !== want.last_byte ||
                   rsp_frame_length !== want.frame_length) begin
                  report_mismatch($sformatf(
                     "beat %0d: expected byte %02h last %0b length %0d, got %02h %0b %0d",
                     beats_seen, want.frame_byte, want.last_byte, want.frame_length,
                     rsp_frame_byte, rsp_last_byte, rsp_frame_length));
               end
               if (want.last_byte) begin
                  frames_read++;
               end
            end
         end
         if (rsp_hold == 0) begin
            if (long_holds_asked > long_holds_done) begin
               long_holds_done++;
               rsp_hold = 200;
            end else begin
               rsp_hold = pick_idle(rsp_calm);
            end
         end
         if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
         if (rsp_calm_left == 0) begin
            rsp_calm = ($urandom_range(0, 3) == 0);
            rsp_calm_left = $urandom_range(50, 300);
         end else begin
            rsp_calm_left--;
         end
      end
   end

   // Stimulus: directed corners, then phases of random frames under swept settings.
   initial begin : stimulus
      int unsigned phase_items;
      int unsigned len;
      int unsigned r;
      logic [15:0] timeouts [0:5];
      logic [7:0]  max_lens [0:5];

      timeouts = '{16'd50, 16'd0, 16'd1, 16'hFFFF, 16'd0, 16'd300};
      max_lens = '{8'd128, 8'd1, 8'd255, 8'd0, 8'd0, 8'd200};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: reads while idle, unused action, a tick to the timer maximum, a short frame.
      add_item(ACT_READ, $urandom, $urandom);
      add_item(ACT_NONE, $urandom, $urandom);
      add_item(ACT_TICK, $urandom, 16'd0);
      add_item(ACT_TICK, $urandom, 16'hFFFF);
      add_item(ACT_TICK, $urandom, $urandom);
      add_item(ACT_BYTE, 8'h00, $urandom);
      add_item(ACT_BYTE, 8'hFF, $urandom);
      add_item(ACT_TICK, $urandom, 16'd49);
      add_item(ACT_BYTE, 8'hA5, $urandom);
      add_item(ACT_TICK, $urandom, 16'd50);
      add_item(ACT_TICK, $urandom, 16'd0);
      add_item(ACT_BYTE, 8'h5A, $urandom);
      add_item(ACT_TICK, $urandom, 16'hFFFF);
      repeat (4) add_item(ACT_READ, $urandom, $urandom);
      drain_block();

      // Zero timeout and zero length: only the opening byte is kept.
      write_reg(CSR_SILENCE_TIMEOUT, 16'd0);
      write_reg(CSR_MAX_LENGTH, 16'hAB00);
      add_item(ACT_BYTE, 8'h80, $urandom);
      add_item(ACT_BYTE, 8'h7F, $urandom);
      add_item(ACT_TICK, $urandom, $urandom);
      add_item(ACT_READ, $urandom, $urandom);
      drain_block();

      // Length limit lowered in the middle of a frame keeps what is already stored.
      write_reg(CSR_SILENCE_TIMEOUT, 16'd10);
      write_reg(CSR_MAX_LENGTH, 16'h00FF);
      add_item(ACT_BYTE, 8'h11, $urandom);
      add_item(ACT_BYTE, 8'h22, $urandom);
      add_item(ACT_BYTE, 8'h33, $urandom);
      drain_block();
      write_reg(CSR_MAX_LENGTH, 16'h5502);
      add_item(ACT_BYTE, 8'h44, $urandom);
      add_item(ACT_TICK, $urandom, 16'd10);
      add_item(ACT_TICK, $urandom, $urandom);
      repeat (3) add_item(ACT_READ, $urandom, $urandom);
      drain_block();

      for (int p = 0; p < 6; p++) begin
         if (p == 4) begin
            timeouts[p] = 16'($urandom_range(2, 400));
            max_lens[p] = 8'($urandom_range(1, 128));
         end
         write_reg(CSR_SILENCE_TIMEOUT, timeouts[p]);
         write_reg(CSR_MAX_LENGTH, {8'($urandom), max_lens[p]});
         phase_items = 0;

         // Long result hold-off while reads keep coming, so the block backs up.
         if (p == 2) begin
            phase_items += add_frame(60);
            while (pending_items.size() > 64) @(negedge clock);
            long_holds_asked++;
         end

         while (phase_items < 65) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
               phase_items += add_noise();
            end else begin
               r = $urandom_range(0, 99);
               if (r < 70) begin
                  len = $urandom_range(1, 10);
               end else if (r < 95) begin
                  len = $urandom_range(11, 48);
               end else begin
                  len = $urandom_range(120, 140);
               end
               phase_items += add_frame(len);
            end
         end
         drain_block();
      end

      repeat (10) @(posedge clock);
      $display("Covered %0d items, %0d beats in %0d frames, %0d register writes.",
               items_taken, beats_seen, frames_read, reg_writes);
      $display("Timeouts from 0 to 65535, length limits from 0 to 255, long hold-off on reads.");
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin : watchdog
      #3000000;
      $display("Timed out with %0d beats still expected.", beats_due.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule

### idle_gap_frame_receiver_core.f
rtl/core/igfr_pkg.sv
rtl/core/igfr_store.sv
rtl/core/igfr_ctrl.sv
rtl/core/idle_gap_frame_receiver_core.sv
dv/idle_gap_frame_receiver_core_test.sv
